// ----- hw/rtl/i2crm_pkg.sv -----
// Shared types and constants for the I2C register master.
package i2crm_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] CfgDeviceAddress = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgHalfPeriod    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgAckTimeout    = 2'd2;

  localparam logic [6:0]  DeviceAddressReset = 7'd83;
  localparam logic [15:0] HalfPeriodReset    = 16'd5;
  localparam logic [7:0]  AckTimeoutReset    = 8'd250;

  typedef enum logic {
    ReqTick    = 1'b0,
    ReqCommand = 1'b1
  } req_type_t;

  typedef struct packed {
    logic       req_type;
    logic       sda_sample;
    logic       op_read;
    logic [7:0] reg_address;
    logic [7:0] write_byte;
    logic [4:0] read_count;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_enable;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_data;
    logic       last_byte;
    logic       done_res;
    logic       ack_error;
  } result_t;

  typedef struct packed {
    logic                     we;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;
  } cfg_write_t;

endpackage

// ----- hw/rtl/i2crm_ifs.sv -----
// Channel interfaces for commands and ticks, result words and configuration writes.
interface i2crm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       sda_sample;
  logic       op_read;
  logic [7:0] reg_address;
  logic [7:0] write_byte;
  logic [4:0] read_count;

  modport source (output valid, output req_type, output sda_sample, output op_read,
                  output reg_address, output write_byte, output read_count, input ready);
  modport sink (input valid, input req_type, input sda_sample, input op_read,
                input reg_address, input write_byte, input read_count, output ready);
endinterface

interface i2crm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive_enable;
  logic       sda_level;
  logic       busy_res;
  logic       byte_valid;
  logic [7:0] read_data;
  logic       last_byte;
  logic       done_res;
  logic       ack_error;

  modport source (output valid, output scl_level, output sda_drive_enable,
                  output sda_level, output busy_res, output byte_valid,
                  output read_data, output last_byte, output done_res,
                  output ack_error, input ready);
  modport sink (input valid, input scl_level, input sda_drive_enable,
                input sda_level, input busy_res, input byte_valid,
                input read_data, input last_byte, input done_res,
                input ack_error, output ready);
endinterface

interface i2crm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/i2c_register_master.sv -----
// Top level of the tick-driven I2C register master.
// The request channel carries two kinds of word. A command word (req_type 1) starts a
// register write or a register read of 1 to MAX_READ (default 16) bytes when the master is idle and is
// ignored otherwise. A tick word (req_type 0) carries the sampled SDA level and moves
// the bus sequencer one tick on. Every request word gives exactly one result word with
// the SCL and SDA drive held during that tick, the busy flag, any byte just received
// (with its last marker) and the done pulse with the ACK error flag.
// Configuration writes on the cfg channel are always taken; index 0 is the device
// address, 1 the half bit period in ticks and 2 the ACK timeout.
// A request word is handled in the cycle it is accepted and its result word is
// presented from the next cycle; one word can be taken every cycle while the result
// buffer has space. The rate is set by the single sequencer step per word.
// A two-entry result buffer holds results while the receiver stalls; request ready
// falls only when both entries are full.
// Reset returns the sequencer to idle, empties the result buffer and restores the
// configuration reset values (address 83, half period 5, timeout 250).
module i2c_register_master
  import i2crm_pkg::*;
#(
  parameter int unsigned MAX_READ = 16
) (
  input  logic         clk,
  input  logic         rst,
  i2crm_cfg_if.sink    cfg,
  i2crm_req_if.sink    request,
  i2crm_res_if.source  result
);

  cfg_write_t cfg_wr;
  item_t      item;
  result_t    step_res;
  result_t    head;
  logic       space;
  logic       step;

  assign cfg.ready    = 1'b1;
  assign cfg_wr.we    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  assign request.ready = space;
  assign step          = request.valid && space;

  assign item.req_type    = request.req_type;
  assign item.sda_sample  = request.sda_sample;
  assign item.op_read     = request.op_read;
  assign item.reg_address = request.reg_address;
  assign item.write_byte  = request.write_byte;
  assign item.read_count  = request.read_count;

  i2crm_core #(
    .MAX_READ(MAX_READ)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .step   (step),
    .item   (item),
    .res    (step_res)
  );

  i2crm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_res),
    .space     (space),
    .valid     (result.valid),
    .ready     (result.ready),
    .head      (head)
  );

  assign result.scl_level        = head.scl_level;
  assign result.sda_drive_enable = head.sda_drive_enable;
  assign result.sda_level        = head.sda_level;
  assign result.busy_res         = head.busy_res;
  assign result.byte_valid       = head.byte_valid;
  assign result.read_data        = head.read_data;
  assign result.last_byte        = head.last_byte;
  assign result.done_res         = head.done_res;
  assign result.ack_error        = head.ack_error;

endmodule

// ----- hw/rtl/i2crm_core.sv -----
// Bus sequencer: configuration registers, transaction state and the per-word step.
module i2crm_core
  import i2crm_pkg::*;
#(
  parameter int unsigned MAX_READ = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_write_t cfg_wr,
  input  logic       step,
  input  item_t      item,
  output result_t    res
);

  typedef enum logic [3:0] {
    PhIdle, PhStartA, PhStartB, PhTxLo, PhTxHi, PhAckLo, PhAckHi, PhRsPrep,
    PhRxLo, PhRxHi, PhMackLo, PhMackHi, PhStopA, PhStopB, PhStopC
  } phase_t;

  typedef enum logic [1:0] {
    StAddrW, StReg, StData, StAddrR
  } stage_t;

  localparam logic [5:0] MaxRead = (MAX_READ > 31) ? 6'd31 : 6'(MAX_READ);

  logic [6:0]  device_address;
  logic [15:0] half_period_ticks;
  logic [7:0]  ack_timeout;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [4:0]  bytes_left, bytes_left_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  timeout_count, timeout_count_next;
  logic [7:0]  latched_register, latched_register_next;
  logic [7:0]  latched_data, latched_data_next;
  logic        latched_is_read, latched_is_read_next;
  logic        error_flag, error_flag_next;

  logic [15:0] hp;
  logic [16:0] tick_inc;
  logic [8:0]  timeout_inc;
  logic [3:0]  bit_inc;
  logic [4:0]  cnt;

  always_comb begin
    hp          = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
    tick_inc    = {1'b0, tick_count} + 17'd1;
    timeout_inc = {1'b0, timeout_count} + 9'd1;
    bit_inc     = bit_index + 4'd1;
    cnt         = (item.read_count == 5'd0) ? 5'd1 : item.read_count;
    if ({1'b0, cnt} > MaxRead) begin
      cnt = MaxRead[4:0];
    end

    phase_next            = phase;
    stage_next            = stage;
    bit_index_next        = bit_index;
    shift_reg_next        = shift_reg;
    bytes_left_next       = bytes_left;
    tick_count_next       = tick_count;
    timeout_count_next    = timeout_count;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    latched_is_read_next  = latched_is_read;
    error_flag_next       = error_flag;

    res                  = '0;
    res.scl_level        = 1'b1;
    res.sda_drive_enable = 1'b1;
    res.sda_level        = 1'b1;
    case (phase)
      PhStartB: res.sda_level = 1'b0;
      PhTxLo: begin
        res.scl_level = 1'b0;
        res.sda_level = shift_reg[7];
      end
      PhTxHi: res.sda_level = shift_reg[7];
      PhAckLo, PhRxLo: begin
        res.scl_level        = 1'b0;
        res.sda_drive_enable = 1'b0;
        res.sda_level        = 1'b0;
      end
      PhAckHi, PhRxHi: begin
        res.sda_drive_enable = 1'b0;
        res.sda_level        = 1'b0;
      end
      PhRsPrep: res.scl_level = 1'b0;
      PhMackLo: begin
        res.scl_level = 1'b0;
        res.sda_level = (bytes_left <= 5'd1);
      end
      PhMackHi: res.sda_level = (bytes_left <= 5'd1);
      PhStopA: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b0;
      end
      PhStopB: res.sda_level = 1'b0;
      default: ;
    endcase

    if (step) begin
      if (item.req_type == ReqCommand) begin
        if (phase == PhIdle) begin
          latched_is_read_next  = item.op_read;
          latched_register_next = item.reg_address;
          latched_data_next     = item.write_byte;
          bytes_left_next       = cnt;
          error_flag_next       = 1'b0;
          timeout_count_next    = '0;
          tick_count_next       = '0;
          bit_index_next        = '0;
          stage_next            = StAddrW;
          shift_reg_next        = {device_address, 1'b0};
          phase_next            = PhStartA;
        end
      end else if (phase != PhIdle) begin
        if (tick_inc < {1'b0, hp}) begin
          tick_count_next = tick_inc[15:0];
        end else begin
          tick_count_next = '0;
          case (phase)
            PhStartA: phase_next = PhStartB;
            PhStartB: begin
              bit_index_next = '0;
              phase_next     = PhTxLo;
            end
            PhTxLo: phase_next = PhTxHi;
            PhTxHi: begin
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_index_next = bit_inc;
              if (bit_inc >= 4'd8) begin
                timeout_count_next = '0;
                phase_next         = PhAckLo;
              end else begin
                phase_next = PhTxLo;
              end
            end
            PhAckLo: phase_next = PhAckHi;
            PhAckHi: begin
              if (!item.sda_sample) begin
                bit_index_next = '0;
                case (stage)
                  StAddrW: begin
                    stage_next     = StReg;
                    shift_reg_next = latched_register;
                    phase_next     = PhTxLo;
                  end
                  StReg: begin
                    if (latched_is_read) begin
                      stage_next     = StAddrR;
                      shift_reg_next = {device_address, 1'b1};
                      phase_next     = PhRsPrep;
                    end else begin
                      stage_next     = StData;
                      shift_reg_next = latched_data;
                      phase_next     = PhTxLo;
                    end
                  end
                  StData: phase_next = PhStopA;
                  default: begin
                    shift_reg_next = '0;
                    phase_next     = PhRxLo;
                  end
                endcase
              end else if (timeout_inc > {1'b0, ack_timeout}) begin
                error_flag_next = 1'b1;
                phase_next      = PhStopA;
              end else begin
                timeout_count_next = timeout_inc[7:0];
                tick_count_next    = hp - 16'd1;
              end
            end
            PhRsPrep: phase_next = PhStartA;
            PhRxLo: phase_next = PhRxHi;
            PhRxHi: begin
              shift_reg_next = {shift_reg[6:0], item.sda_sample};
              bit_index_next = bit_inc;
              if (bit_inc >= 4'd8) begin
                res.byte_valid = 1'b1;
                res.read_data  = {shift_reg[6:0], item.sda_sample};
                res.last_byte  = (bytes_left <= 5'd1);
                phase_next     = PhMackLo;
              end else begin
                phase_next = PhRxLo;
              end
            end
            PhMackLo: phase_next = PhMackHi;
            PhMackHi: begin
              if (bytes_left <= 5'd1) begin
                bytes_left_next = '0;
                phase_next      = PhStopA;
              end else begin
                bytes_left_next = bytes_left - 5'd1;
                bit_index_next  = '0;
                shift_reg_next  = '0;
                phase_next      = PhRxLo;
              end
            end
            PhStopA: phase_next = PhStopB;
            PhStopB: phase_next = PhStopC;
            PhStopC: begin
              res.done_res  = 1'b1;
              res.ack_error = error_flag;
              phase_next    = PhIdle;
            end
            default: phase_next = PhIdle;
          endcase
        end
      end
    end

    res.busy_res = (phase != PhIdle) || (phase_next != PhIdle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= DeviceAddressReset;
      half_period_ticks <= HalfPeriodReset;
      ack_timeout       <= AckTimeoutReset;
      phase             <= PhIdle;
      stage             <= StAddrW;
      bit_index         <= '0;
      shift_reg         <= '0;
      bytes_left        <= '0;
      tick_count        <= '0;
      timeout_count     <= '0;
      latched_register  <= '0;
      latched_data      <= '0;
      latched_is_read   <= 1'b0;
      error_flag        <= 1'b0;
    end else begin
      if (cfg_wr.we) begin
        case (cfg_wr.index)
          CfgDeviceAddress: device_address <= cfg_wr.data[6:0];
          CfgHalfPeriod:    half_period_ticks <= cfg_wr.data;
          CfgAckTimeout:    ack_timeout <= cfg_wr.data[7:0];
          default: ;
        endcase
      end
      phase            <= phase_next;
      stage            <= stage_next;
      bit_index        <= bit_index_next;
      shift_reg        <= shift_reg_next;
      bytes_left       <= bytes_left_next;
      tick_count       <= tick_count_next;
      timeout_count    <= timeout_count_next;
      latched_register <= latched_register_next;
      latched_data     <= latched_data_next;
      latched_is_read  <= latched_is_read_next;
      error_flag       <= error_flag_next;
    end
  end

endmodule

// ----- hw/rtl/i2crm_obuf.sv -----
// Two-entry result buffer that decouples the result channel from the request channel.
module i2crm_obuf
  import i2crm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    valid,
  input  logic    ready,
  output result_t head
);

  result_t    entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign space = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign pop   = valid && ready;
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- verif/tb_i2c_register_master.sv -----
// Self-checking testbench for the tick-driven I2C register master.
`timescale 1ns / 1ps

module tb_i2c_register_master;
  import i2crm_pkg::*;

  localparam int MaxRead = 16;
  localparam int unsigned CycleLimit = 800000;
  localparam logic [CfgIndexWidth-1:0] CfgSpare = 2'd3;

  typedef enum logic [3:0] {
    SeqIdle, SeqStartA, SeqStartB, SeqTxLow, SeqTxHigh, SeqAckLow, SeqAckHigh,
    SeqRestart, SeqRxLow, SeqRxHigh, SeqMackLow, SeqMackHigh, SeqStopA, SeqStopB,
    SeqStopC
  } seq_phase_t;

  typedef enum logic [1:0] {
    ByteAddrWrite, ByteRegister, ByteData, ByteAddrRead
  } byte_stage_t;

  logic clk;
  logic rst;

  i2crm_cfg_if cfg_ch ();
  i2crm_req_if req_ch ();
  i2crm_res_if res_ch ();

  i2c_register_master #(
    .MAX_READ(MaxRead)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .request(req_ch),
    .result(res_ch)
  );

  logic [6:0]  target_addr = DeviceAddressReset;
  logic [15:0] half_period = HalfPeriodReset;
  logic [7:0]  ack_limit   = AckTimeoutReset;

  seq_phase_t  bus_phase  = SeqIdle;
  byte_stage_t stage      = ByteAddrWrite;
  logic [3:0]  bit_cnt    = '0;
  logic [7:0]  shifter    = '0;
  logic [4:0]  bytes_left = '0;
  logic [15:0] tick_cnt   = '0;
  logic [7:0]  ack_wait   = '0;
  logic [7:0]  reg_latch  = '0;
  logic [7:0]  data_latch = '0;
  logic        is_read    = 1'b0;
  logic        err_flag   = 1'b0;

  item_t   pending_words[$];
  result_t due_results[$];
  item_t   word_now;

  int unsigned gap_left = 0;
  int unsigned send_streak = 0;
  int unsigned stall_left = 0;
  int unsigned take_streak = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;
  int unsigned item_tally = 0;

  function automatic result_t step_sequencer(item_t w);
    result_t r;
    seq_phase_t prior;
    logic [15:0] hp;
    logic [16:0] t;
    logic [8:0] c;
    logic [4:0] cnt;
    r = '0;
    prior = bus_phase;
    r.scl_level = 1'b1;
    r.sda_drive_enable = 1'b1;
    r.sda_level = 1'b1;
    case (prior)
      SeqStartB: r.sda_level = 1'b0;
      SeqTxLow: begin
        r.scl_level = 1'b0;
        r.sda_level = shifter[7];
      end
      SeqTxHigh: r.sda_level = shifter[7];
      SeqAckLow, SeqRxLow: begin
        r.scl_level = 1'b0;
        r.sda_drive_enable = 1'b0;
        r.sda_level = 1'b0;
      end
      SeqAckHigh, SeqRxHigh: begin
        r.sda_drive_enable = 1'b0;
        r.sda_level = 1'b0;
      end
      SeqRestart: r.scl_level = 1'b0;
      SeqMackLow: begin
        r.scl_level = 1'b0;
        r.sda_level = (bytes_left <= 5'd1);
      end
      SeqMackHigh: r.sda_level = (bytes_left <= 5'd1);
      SeqStopA: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
      end
      SeqStopB: r.sda_level = 1'b0;
      default: ;
    endcase
    if (w.req_type == ReqCommand) begin
      if (bus_phase == SeqIdle) begin
        cnt = w.read_count;
        if (cnt == 5'd0) cnt = 5'd1;
        if (cnt > MaxRead) cnt = 5'(MaxRead);
        is_read = w.op_read;
        reg_latch = w.reg_address;
        data_latch = w.write_byte;
        bytes_left = cnt;
        err_flag = 1'b0;
        ack_wait = '0;
        tick_cnt = '0;
        bit_cnt = '0;
        stage = ByteAddrWrite;
        shifter = {target_addr, 1'b0};
        bus_phase = SeqStartA;
      end
    end else if (bus_phase != SeqIdle) begin
      hp = (half_period == 16'd0) ? 16'd1 : half_period;
      t = {1'b0, tick_cnt} + 17'd1;
      if (t < {1'b0, hp}) begin
        tick_cnt = t[15:0];
      end else begin
        tick_cnt = '0;
        case (bus_phase)
          SeqStartA: bus_phase = SeqStartB;
          SeqStartB: begin
            bit_cnt = '0;
            bus_phase = SeqTxLow;
          end
          SeqTxLow: bus_phase = SeqTxHigh;
          SeqTxHigh: begin
            shifter = shifter << 1;
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              ack_wait = '0;
              bus_phase = SeqAckLow;
            end else begin
              bus_phase = SeqTxLow;
            end
          end
          SeqAckLow: bus_phase = SeqAckHigh;
          SeqAckHigh: begin
            if (!w.sda_sample) begin
              bit_cnt = '0;
              case (stage)
                ByteAddrWrite: begin
                  stage = ByteRegister;
                  shifter = reg_latch;
                  bus_phase = SeqTxLow;
                end
                ByteRegister: begin
                  if (is_read) begin
                    stage = ByteAddrRead;
                    shifter = {target_addr, 1'b1};
                    bus_phase = SeqRestart;
                  end else begin
                    stage = ByteData;
                    shifter = data_latch;
                    bus_phase = SeqTxLow;
                  end
                end
                ByteData: bus_phase = SeqStopA;
                default: begin
                  shifter = '0;
                  bus_phase = SeqRxLow;
                end
              endcase
            end else begin
              c = {1'b0, ack_wait} + 9'd1;
              if (c > {1'b0, ack_limit}) begin
                err_flag = 1'b1;
                bus_phase = SeqStopA;
              end else begin
                ack_wait = c[7:0];
                tick_cnt = hp - 16'd1;
              end
            end
          end
          SeqRestart: bus_phase = SeqStartA;
          SeqRxLow: bus_phase = SeqRxHigh;
          SeqRxHigh: begin
            shifter = {shifter[6:0], w.sda_sample};
            bit_cnt = bit_cnt + 4'd1;
            if (bit_cnt >= 4'd8) begin
              r.byte_valid = 1'b1;
              r.read_data = shifter;
              r.last_byte = (bytes_left <= 5'd1);
              bus_phase = SeqMackLow;
            end else begin
              bus_phase = SeqRxLow;
            end
          end
          SeqMackLow: bus_phase = SeqMackHigh;
          SeqMackHigh: begin
            if (bytes_left <= 5'd1) begin
              bytes_left = '0;
              bus_phase = SeqStopA;
            end else begin
              bytes_left = bytes_left - 5'd1;
              bit_cnt = '0;
              shifter = '0;
              bus_phase = SeqRxLow;
            end
          end
          SeqStopA: bus_phase = SeqStopB;
          SeqStopB: bus_phase = SeqStopC;
          SeqStopC: begin
            r.done_res = 1'b1;
            r.ack_error = err_flag;
            bus_phase = SeqIdle;
          end
          default: bus_phase = SeqIdle;
        endcase
      end
    end
    r.busy_res = (prior != SeqIdle) || (bus_phase != SeqIdle);
    return r;
  endfunction

  function automatic int unsigned idle_len(inout int unsigned streak);
    int unsigned roll;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 2) streak = $urandom_range(150, 40);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic item_t tick_word(int unsigned low_odds);
    item_t w;
    logic [31:0] rnd;
    rnd = $urandom;
    w.req_type = ReqTick;
    w.sda_sample = ($urandom_range(7) < low_odds) ? 1'b0 : 1'b1;
    w.op_read = rnd[0];
    w.reg_address = rnd[8:1];
    w.write_byte = rnd[16:9];
    w.read_count = rnd[21:17];
    return w;
  endfunction

  function automatic item_t command_word(logic op, logic [7:0] reg_addr,
                                         logic [7:0] data_byte, logic [4:0] count);
    item_t w;
    logic [31:0] rnd;
    rnd = $urandom;
    w.req_type = ReqCommand;
    w.sda_sample = rnd[0];
    w.op_read = op;
    w.reg_address = reg_addr;
    w.write_byte = data_byte;
    w.read_count = count;
    return w;
  endfunction

  task automatic enqueue(item_t w);
    pending_words.push_back(w);
    item_tally++;
  endtask

  task automatic queue_transfer(logic op, logic [7:0] reg_addr, logic [7:0] data_byte,
                                logic [4:0] count, int unsigned low_odds);
    int unsigned n, steps, hp, ticks, cut, i;
    n = (count == 5'd0) ? 1 : ((count > MaxRead) ? MaxRead : count);
    steps = op ? 62 + 18 * n : 59;
    hp = (half_period == 16'd0) ? 1 : half_period;
    ticks = steps * hp + $urandom_range(6);
    cut = ($urandom_range(4) == 0) ? $urandom_range(ticks - 1) : ticks;
    enqueue(command_word(op, reg_addr, data_byte, count));
    for (i = 0; i < ticks; i++) begin
      if (i == cut) enqueue(command_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                                         8'($urandom_range(255)), 5'($urandom_range(31))));
      enqueue(tick_word(low_odds));
    end
  endtask

  // The sender holds off until the bus is idle and every result word is back.
  task automatic settle();
    do begin
      if (bus_phase != SeqIdle) repeat (64) enqueue(tick_word(8));
      while (pending_words.size() != 0 || req_ch.valid || due_results.size() != 0)
        @(negedge clk);
    end while (bus_phase != SeqIdle);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [CfgIndexWidth-1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    case (idx)
      CfgDeviceAddress: target_addr = value[6:0];
      CfgHalfPeriod: half_period = value;
      CfgAckTimeout: ack_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    $display("cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("word %0d %s got %0h expected %0h", results_seen, name, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= ReqTick;
      req_ch.sda_sample <= 1'b0;
      req_ch.op_read <= 1'b0;
      req_ch.reg_address <= '0;
      req_ch.write_byte <= '0;
      req_ch.read_count <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) due_results.push_back(step_sequencer(word_now));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_now = pending_words.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= word_now.req_type;
          req_ch.sda_sample <= word_now.sda_sample;
          req_ch.op_read <= word_now.op_read;
          req_ch.reg_address <= word_now.reg_address;
          req_ch.write_byte <= word_now.write_byte;
          req_ch.read_count <= word_now.read_count;
          gap_left = idle_len(send_streak);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("word %0d arrived with nothing expected", results_seen));
        end else begin
          result_t want;
          want = due_results.pop_front();
          compare_field("scl_level", 8'(res_ch.scl_level), 8'(want.scl_level));
          compare_field("sda_drive_enable", 8'(res_ch.sda_drive_enable),
                        8'(want.sda_drive_enable));
          compare_field("sda_level", 8'(res_ch.sda_level), 8'(want.sda_level));
          compare_field("busy_res", 8'(res_ch.busy_res), 8'(want.busy_res));
          compare_field("byte_valid", 8'(res_ch.byte_valid), 8'(want.byte_valid));
          compare_field("read_data", res_ch.read_data, want.read_data);
          compare_field("last_byte", 8'(res_ch.last_byte), 8'(want.last_byte));
          compare_field("done_res", 8'(res_ch.done_res), 8'(want.done_res));
          compare_field("ack_error", 8'(res_ch.ack_error), 8'(want.ack_error));
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = idle_len(take_streak);
      end
    end
  end

  initial begin
    logic [31:0] rnd;
    int unsigned pick, roll, odds;
    logic [4:0] count;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgDeviceAddress;
    cfg_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    enqueue(tick_word(0));
    enqueue(tick_word(8));
    queue_transfer(1'b0, 8'h00, 8'hFF, 5'd0, 8);
    settle();

    // Upper data bits are outside the fields and a zero half period counts as one tick.
    write_register(CfgDeviceAddress, 16'hFF80);
    write_register(CfgHalfPeriod, 16'h0000);
    write_register(CfgAckTimeout, 16'hFF01);
    write_register(CfgSpare, 16'hFFFF);
    queue_transfer(1'b1, 8'h81, 8'h7E, 5'd31, 7);
    queue_transfer(1'b1, 8'hFF, 8'h00, 5'd0, 6);
    enqueue(command_word(1'b0, 8'h5A, 8'hA5, 5'd1));
    queue_transfer(1'b1, 8'hA5, 8'h5A, 5'd2, 7);
    queue_transfer(1'b0, 8'hF0, 8'h0F, 5'd8, 0);
    settle();

    write_register(CfgDeviceAddress, 16'h007F);
    write_register(CfgHalfPeriod, 16'd1);
    write_register(CfgAckTimeout, 16'h00FF);
    queue_transfer(1'b0, 8'h12, 8'h34, 5'd1, 0);
    queue_transfer(1'b1, 8'h0F, 8'hF0, 5'd1, 8);
    settle();

    write_register(CfgHalfPeriod, 16'hFFFF);
    repeat (4) enqueue(tick_word(4));
    settle();

    while (item_tally < 1400) begin
      rnd = $urandom;
      case ($urandom_range(3))
        0: pick = 0;
        1: pick = 127;
        default: pick = $urandom_range(127);
      endcase
      write_register(CfgDeviceAddress, {rnd[15:7], pick[6:0]});
      case ($urandom_range(5))
        0: pick = 0;
        4: pick = 2;
        5: pick = 3;
        default: pick = 1;
      endcase
      write_register(CfgHalfPeriod, pick[15:0]);
      roll = $urandom_range(19);
      if (roll == 0) pick = 255;
      else if (roll < 12) pick = $urandom_range(3, 1);
      else pick = $urandom_range(8, 4);
      write_register(CfgAckTimeout, {rnd[31:24], pick[7:0]});
      if ($urandom_range(3) == 0) write_register(CfgSpare, rnd[23:8]);

      repeat ($urandom_range(3, 1)) begin
        rnd = $urandom;
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(30, 5)) begin
            item_t w;
            w = tick_word($urandom_range(8));
            if ($urandom_range(7) == 0) w.req_type = ReqCommand;
            enqueue(w);
          end
        end else begin
          roll = $urandom_range(7);
          if (roll == 0) count = 5'd16;
          else if (roll == 1) count = rnd[16] ? 5'd0 : 5'($urandom_range(31, 17));
          else count = 5'($urandom_range(4, 1));
          roll = $urandom_range(9);
          odds = (roll == 0) ? 0 : (roll == 1) ? 3 : (roll < 4) ? 5 : 7;
          queue_transfer(rnd[17], rnd[7:0], rnd[15:8], count, odds);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
